// ===== src/assert_macros.svh =====
// Assertion macros shared by the tachometer RTL.
// Needs clk_i, and rst_ni for RPMF_ASSERT, in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define RPMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define RPMF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/rpmf_pkg.sv =====
// Package for the tachometer period filter: widths, register indexes,
// controller/datapath command and status types and the segment table.
`timescale 1ns / 1ps

package rpmf_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int CAP_W  = 16;
  localparam int NUM_W  = 26;
  localparam int RPM_W  = 14;
  localparam int CHG_W  = 8;
  localparam int OVF_W  = 4;
  localparam int SEG_W  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 26;
  localparam int BCD_W  = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd5;

  localparam logic [NUM_W-1:0] NUMERATOR_RST = 26'd60000000;
  localparam logic [RPM_W-1:0] MAX_RPM_RST   = 14'd7000;
  localparam logic [CHG_W-1:0] MIN_CHG_RST   = 8'd3;
  localparam logic [RPM_W-1:0] HIGH_BAND_RST = 14'd5700;
  localparam logic [RPM_W-1:0] MAX_JUMP_RST  = 14'd175;
  localparam logic [OVF_W-1:0] TIMEOUT_RST   = 4'd7;

  localparam logic CMD_OVERFLOW = 1'b0;
  localparam logic CMD_CAPTURE  = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic filt;
    logic bcd_init;
    logic bcd_step;
    logic out_load;
  } rpmf_cmd_t;

  typedef struct packed {
    logic period_zero;
  } rpmf_status_t;

  function automatic logic [SEG_W-1:0] seg_of(logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/rpm_meter_period_filter_top.sv =====
// Top level of the tachometer period filter.
// Instantiates rpmf_ctrl and rpmf_datapath; uses rpmf_pkg.
//
// Usage: each input item is either a timer overflow (cmd_i = 0) or a capture
// (cmd_i = 1, capture_value_i holds the latched count). Every item gives one
// result: the shown rpm, four seven-segment codes and the stopped flag.
// Items are taken on the in channel (in_valid_i, in_stall_o) and results
// leave on the out channel (out_valid_o, out_stall_i); an item moves on a
// clock edge with valid high and stall low.
// The block works on one item at a time. An accepted overflow item passes
// S_BCD_INIT, S_BCD and S_OUT; a capture first passes S_CHECK and, unless its
// period is zero, S_DIV (the one-bit-per-cycle restoring divider) and S_FILT.
// S_BCD is the two-bit-per-cycle decimal conversion. The edge on which S_OUT
// finds the output free registers the result and makes the block ready again.
// The result sits in an output register, so the next item is taken while a
// result is still waiting; if the receiver keeps stalling, the following
// result waits in the block and in_stall_o stays high.
// Reset loads the default configuration and clears the overflow count, the
// shown rpm and the stopped flag. Configuration is written on cfg_we_i.
`timescale 1ns / 1ps

module rpm_meter_period_filter_top
  import rpmf_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [CAP_W-1:0]      capture_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RPM_W-1:0]      rpm_o,
  output logic [SEG_W-1:0]      seg_thousands_o,
  output logic [SEG_W-1:0]      seg_hundreds_o,
  output logic [SEG_W-1:0]      seg_tens_o,
  output logic [SEG_W-1:0]      seg_ones_o,
  output logic                  stopped_o
);

  rpmf_cmd_t    cmd;
  rpmf_status_t status;

  rpmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rpmf_datapath #(
    .TIMER_BITS (TIMER_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd_i),
    .capture_value_i (capture_value_i),
    .cmd_in_i        (cmd),
    .status_o        (status),
    .rpm_o           (rpm_o),
    .seg_thousands_o (seg_thousands_o),
    .seg_hundreds_o  (seg_hundreds_o),
    .seg_tens_o      (seg_tens_o),
    .seg_ones_o      (seg_ones_o),
    .stopped_o       (stopped_o)
  );

endmodule

// ===== src/rpmf_ctrl.sv =====
// Controller state machine of the tachometer: sequences division, filter,
// binary-to-decimal conversion and the output register. Uses rpmf_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpmf_ctrl
  import rpmf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic         cmd_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  rpmf_status_t status_i,
  output rpmf_cmd_t    cmd_o
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam int BCD_STEPS = RPM_W / 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_FILT,
    S_BCD_INIT,
    S_BCD,
    S_OUT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             out_valid_d;
  logic             accept;
  logic             slot_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // A waiting result stays until taken; a new one is loaded as the slot frees.
  assign out_valid_d = ((state_q == S_OUT) && slot_free) || (out_valid_q && out_stall_i);

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.filt     = (state_q == S_FILT);
    cmd_o.bcd_init = (state_q == S_BCD_INIT);
    cmd_o.bcd_step = (state_q == S_BCD);
    cmd_o.out_load = (state_q == S_OUT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= (cmd_i == CMD_CAPTURE) ? S_CHECK : S_BCD_INIT;
          end
        end
        S_CHECK: begin
          cnt_q   <= '0;
          state_q <= status_i.period_zero ? S_BCD_INIT : S_DIV;
        end
        S_DIV: begin
          if (cnt_q == CNT_W'(NUM_W - 1)) begin
            state_q <= S_FILT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FILT: begin
          state_q <= S_BCD_INIT;
        end
        S_BCD_INIT: begin
          cnt_q   <= '0;
          state_q <= S_BCD;
        end
        S_BCD: begin
          if (cnt_q == CNT_W'(BCD_STEPS - 1)) begin
            state_q <= S_OUT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `RPMF_ASSERT(a_accept_goes_busy, accept |=> in_stall_o, "item accepted but block not busy")
  `RPMF_ASSERT(a_result_from_out, $rose(out_valid_q) |-> $past(state_q == S_OUT),
               "result shown outside the output state")
  `RPMF_ASSERT(a_div_count, (state_q == S_DIV) |-> (cnt_q < CNT_W'(NUM_W)),
               "division step count out of range")

endmodule

// ===== src/rpmf_datapath.sv =====
// Datapath of the tachometer: configuration registers, overflow counter,
// period former, restoring divider, plausibility filter, decimal conversion
// and the output register. Uses rpmf_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpmf_datapath
  import rpmf_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  cmd_i,
  input  logic [CAP_W-1:0]      capture_value_i,
  input  rpmf_cmd_t             cmd_in_i,
  output rpmf_status_t          status_o,
  output logic [RPM_W-1:0]      rpm_o,
  output logic [SEG_W-1:0]      seg_thousands_o,
  output logic [SEG_W-1:0]      seg_hundreds_o,
  output logic [SEG_W-1:0]      seg_tens_o,
  output logic [SEG_W-1:0]      seg_ones_o,
  output logic                  stopped_o
);

  // Period holds up to (timeout + 1) timer wraps plus the capture.
  localparam int PW = ((TIMER_BITS > CAP_W) ? TIMER_BITS : CAP_W) + OVF_W + 1;
  localparam logic [PW-1:0] TIMER_MAX = PW'((64'd1 << TIMER_BITS) - 64'd1);
  localparam int DD_W = BCD_W + RPM_W;

  logic [NUM_W-1:0] numerator_q;
  logic [RPM_W-1:0] max_rpm_q, high_band_q, max_jump_q;
  logic [CHG_W-1:0] min_chg_q;
  logic [OVF_W-1:0] timeout_q;

  logic [OVF_W-1:0] ovf_q;
  logic             stopped_q;
  logic [RPM_W-1:0] shown_q;
  logic [PW-1:0]    period_q;
  logic [PW-1:0]    rem_q;
  logic [NUM_W-1:0] quot_q;
  logic [DD_W-1:0]  dd_q;

  logic [RPM_W-1:0] rpm_out_q;
  logic [SEG_W-1:0] seg_th_q, seg_hu_q, seg_te_q, seg_on_q;
  logic             stopped_out_q;

  logic [OVF_W:0]   ovf_sum;
  logic [PW-1:0]    period_d;
  logic [PW:0]      trial;
  logic [PW:0]      trial_sub;
  logic             trial_ge;
  logic [NUM_W-1:0] diff;
  logic             cand_ok;
  logic [3:0]       d_tt, d_th, d_hu, d_te, d_on;

  function automatic logic [DD_W-1:0] dd_bit(logic [DD_W-1:0] v);
    logic [DD_W-1:0] r;
    r = v;
    for (int k = 0; k < BCD_W / 4; k++) begin
      if (r[RPM_W + 4*k +: 4] >= 4'd5) begin
        r[RPM_W + 4*k +: 4] = r[RPM_W + 4*k +: 4] + 4'd3;
      end
    end
    return {r[DD_W-2:0], 1'b0};
  endfunction

  assign ovf_sum  = {1'b0, ovf_q} + {{OVF_W{1'b0}}, stopped_q};
  assign period_d = (PW'(ovf_sum) << TIMER_BITS) - PW'(ovf_sum)
                  + (PW'(capture_value_i) & TIMER_MAX);

  assign trial     = {rem_q, quot_q[NUM_W-1]};
  assign trial_ge  = (trial >= {1'b0, period_q});
  assign trial_sub = trial - {1'b0, period_q};

  assign diff = (quot_q >= NUM_W'(shown_q)) ? (quot_q - NUM_W'(shown_q))
                                            : (NUM_W'(shown_q) - quot_q);
  assign cand_ok = (quot_q < NUM_W'(max_rpm_q)) && (diff >= NUM_W'(min_chg_q)) &&
                   ((quot_q <= NUM_W'(high_band_q)) || (diff < NUM_W'(max_jump_q)));

  assign status_o.period_zero = (period_q == '0);

  assign d_tt = dd_q[RPM_W + 16 +: 4];
  assign d_th = dd_q[RPM_W + 12 +: 4];
  assign d_hu = dd_q[RPM_W + 8 +: 4];
  assign d_te = dd_q[RPM_W + 4 +: 4];
  assign d_on = dd_q[RPM_W +: 4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numerator_q <= NUMERATOR_RST;
      max_rpm_q   <= MAX_RPM_RST;
      min_chg_q   <= MIN_CHG_RST;
      high_band_q <= HIGH_BAND_RST;
      max_jump_q  <= MAX_JUMP_RST;
      timeout_q   <= TIMEOUT_RST;
      ovf_q       <= '0;
      stopped_q   <= 1'b0;
      shown_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NUMERATOR: numerator_q <= cfg_data_i[NUM_W-1:0];
          CFG_MAX_RPM:   max_rpm_q   <= cfg_data_i[RPM_W-1:0];
          CFG_MIN_CHG:   min_chg_q   <= cfg_data_i[CHG_W-1:0];
          CFG_HIGH_BAND: high_band_q <= cfg_data_i[RPM_W-1:0];
          CFG_MAX_JUMP:  max_jump_q  <= cfg_data_i[RPM_W-1:0];
          CFG_TIMEOUT:   timeout_q   <= cfg_data_i[OVF_W-1:0];
          default: ;
        endcase
      end
      if (cmd_in_i.accept) begin
        if (cmd_i == CMD_OVERFLOW) begin
          if (ovf_q < timeout_q) begin
            ovf_q <= ovf_q + 1'b1;
          end else begin
            stopped_q <= 1'b1;
            shown_q   <= '0;
          end
        end else begin
          ovf_q     <= '0;
          stopped_q <= 1'b0;
        end
      end
      if (cmd_in_i.filt && cand_ok) begin
        shown_q <= quot_q[RPM_W-1:0];
      end
    end
  end

  // Working registers of the divider and converter and the output register carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.accept) begin
      period_q <= period_d;
      rem_q    <= '0;
      quot_q   <= numerator_q;
    end else if (cmd_in_i.div_step) begin
      rem_q  <= trial_ge ? trial_sub[PW-1:0] : trial[PW-1:0];
      quot_q <= {quot_q[NUM_W-2:0], trial_ge};
    end
    if (cmd_in_i.bcd_init) begin
      dd_q <= {{BCD_W{1'b0}}, shown_q};
    end else if (cmd_in_i.bcd_step) begin
      dd_q <= dd_bit(dd_bit(dd_q));
    end
    if (cmd_in_i.out_load) begin
      rpm_out_q     <= shown_q;
      seg_th_q      <= (d_tt != 4'd0) ? '0 : seg_of(d_th);
      seg_hu_q      <= seg_of(d_hu);
      seg_te_q      <= seg_of(d_te);
      seg_on_q      <= seg_of(d_on);
      stopped_out_q <= stopped_q;
    end
  end

  assign rpm_o           = rpm_out_q;
  assign seg_thousands_o = seg_th_q;
  assign seg_hundreds_o  = seg_hu_q;
  assign seg_tens_o      = seg_te_q;
  assign seg_ones_o      = seg_on_q;
  assign stopped_o       = stopped_out_q;

  `RPMF_ASSERT_ALWAYS(a_stop_zero, stopped_q |-> (shown_q == '0),
                      "motor stopped but shown rpm is not zero")
  `RPMF_ASSERT(a_shown_change, (shown_q != $past(shown_q)) |-> ((shown_q == '0) || $past(cmd_in_i.filt)),
               "shown rpm changed outside the filter step")

endmodule

// ===== tb/rpm_meter_period_filter_checker.sv =====
// Checker for the tachometer period filter. It watches the register port and both item
// channels, keeps its own model of the counters and the filter, and compares every result.
// Depends on rpmf_pkg for widths, register indexes, reset values and command codes.
`timescale 1ns / 1ps

module rpm_meter_period_filter_checker
  import rpmf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  cmd_i,
  input  logic [CAP_W-1:0]      capture_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [RPM_W-1:0]      rpm_i,
  input  logic [SEG_W-1:0]      seg_thousands_i,
  input  logic [SEG_W-1:0]      seg_hundreds_i,
  input  logic [SEG_W-1:0]      seg_tens_i,
  input  logic [SEG_W-1:0]      seg_ones_i,
  input  logic                  stopped_i,
  output int                    error_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    stop_seen_o
);

  localparam int unsigned TIMER_MAX = (1 << TIMER_BITS_DEFAULT) - 1;

  // Segment codes for the digits nine down to zero, digit zero in the low bits.
  localparam logic [10*SEG_W-1:0] SEG_CODES = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic [SEG_W-1:0] seg_thousands;
    logic [SEG_W-1:0] seg_hundreds;
    logic [SEG_W-1:0] seg_tens;
    logic [SEG_W-1:0] seg_ones;
    logic             stopped;
  } reading_t;

  logic [NUM_W-1:0] numerator_q;
  logic [RPM_W-1:0] max_rpm_q;
  logic [CHG_W-1:0] min_change_q;
  logic [RPM_W-1:0] high_band_q;
  logic [RPM_W-1:0] max_jump_q;
  logic [OVF_W-1:0] timeout_q;

  logic [OVF_W-1:0] overflow_cnt;
  logic [RPM_W-1:0] shown_rpm;
  logic             stop_flag;

  reading_t readings_q[$];
  reading_t want;
  reading_t got;
  int       errors;
  int       checked;
  int       stops;

  function automatic logic [SEG_W-1:0] digit_segments(input int unsigned digit);
    logic [SEG_W-1:0] code;
    code = '0;
    if (digit < 10) code = SEG_CODES[digit*SEG_W +: SEG_W];
    return code;
  endfunction

  // Advances the model by one item and returns the reading that item leaves on display.
  function automatic reading_t next_reading(input logic cmd, input logic [CAP_W-1:0] cap);
    logic [31:0] ovf_total;
    logic [31:0] period;
    logic [31:0] cand;
    logic [31:0] shown32;
    logic [31:0] diff;
    reading_t    r;
    if (cmd == CMD_OVERFLOW) begin
      if (overflow_cnt < timeout_q) begin
        overflow_cnt = overflow_cnt + 1'b1;
      end else begin
        stop_flag = 1'b1;
        shown_rpm = '0;
      end
    end else begin
      // After a stop the held count misses the overflow that set the stop flag.
      ovf_total = {28'd0, overflow_cnt} + {31'd0, stop_flag};
      period    = ovf_total * TIMER_MAX + {16'd0, cap};
      overflow_cnt = '0;
      stop_flag    = 1'b0;
      if (period != 0) begin
        cand    = {6'd0, numerator_q} / period;
        shown32 = {18'd0, shown_rpm};
        diff    = (cand >= shown32) ? cand - shown32 : shown32 - cand;
        if (cand < {18'd0, max_rpm_q} && diff >= {24'd0, min_change_q} &&
            (cand <= {18'd0, high_band_q} || diff < {18'd0, max_jump_q})) begin
          shown_rpm = cand[RPM_W-1:0];
        end
      end
    end
    shown32         = {18'd0, shown_rpm};
    r.rpm           = shown_rpm;
    r.seg_thousands = digit_segments(shown32 / 1000);
    r.seg_hundreds  = digit_segments((shown32 / 100) % 10);
    r.seg_tens      = digit_segments((shown32 / 10) % 10);
    r.seg_ones      = digit_segments(shown32 % 10);
    r.stopped       = stop_flag;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numerator_q  = NUMERATOR_RST;
      max_rpm_q    = MAX_RPM_RST;
      min_change_q = MIN_CHG_RST;
      high_band_q  = HIGH_BAND_RST;
      max_jump_q   = MAX_JUMP_RST;
      timeout_q    = TIMEOUT_RST;
      overflow_cnt = '0;
      shown_rpm    = '0;
      stop_flag    = 1'b0;
      readings_q.delete();
      errors  = 0;
      checked = 0;
      stops   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUMERATOR: numerator_q  = cfg_data_i[NUM_W-1:0];
          CFG_MAX_RPM:   max_rpm_q    = cfg_data_i[RPM_W-1:0];
          CFG_MIN_CHG:   min_change_q = cfg_data_i[CHG_W-1:0];
          CFG_HIGH_BAND: high_band_q  = cfg_data_i[RPM_W-1:0];
          CFG_MAX_JUMP:  max_jump_q   = cfg_data_i[RPM_W-1:0];
          CFG_TIMEOUT:   timeout_q    = cfg_data_i[OVF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        readings_q.push_back(next_reading(cmd_i, capture_value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{rpm_i, seg_thousands_i, seg_hundreds_i, seg_tens_i, seg_ones_i, stopped_i};
        checked++;
        if (stopped_i) stops++;
        if (readings_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result with no item outstanding: rpm %0d stopped %b",
                     $realtime, rpm_i, stopped_i);
          end
        end else begin
          want = readings_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result %0d mismatch, expected rpm %0d seg %h %h %h %h stop %b",
                       $realtime, checked, want.rpm, want.seg_thousands, want.seg_hundreds,
                       want.seg_tens, want.seg_ones, want.stopped);
              $display("%0t:   got rpm %0d seg %h %h %h %h stop %b",
                       $realtime, got.rpm, got.seg_thousands, got.seg_hundreds,
                       got.seg_tens, got.seg_ones, got.stopped);
            end
          end
        end
      end
    end
    error_count_o <= errors;
    pending_o     <= readings_q.size();
    checked_o     <= checked;
    stop_seen_o   <= stops;
  end

endmodule

// ===== tb/rpm_meter_period_filter_top_test.sv =====
// Top of the tachometer period filter testbench: clock, reset, register writes, item
// stimulus and receiver stalls. Instantiates rpm_meter_period_filter_top and
// rpm_meter_period_filter_checker; uses rpmf_pkg.
`timescale 1ns / 1ps

module rpm_meter_period_filter_top_test;
  import rpmf_pkg::*;

  // Indexes past the register list; writes to them must have no effect.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int unsigned TIMER_MAX    = (1 << TIMER_BITS_DEFAULT) - 1;
  localparam int          RUN_LIMIT_NS = 2_000_000;
  localparam int          SETTLE_CYC   = 4;
  localparam int          TAIL_CYC     = 60;
  localparam int          HOLD_CYC     = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  cmd = CMD_OVERFLOW;
  logic [CAP_W-1:0]      capture_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RPM_W-1:0]      rpm;
  logic [SEG_W-1:0]      seg_thousands;
  logic [SEG_W-1:0]      seg_hundreds;
  logic [SEG_W-1:0]      seg_tens;
  logic [SEG_W-1:0]      seg_ones;
  logic                  stopped;

  int error_count;
  int pending;
  int checked;
  int stop_seen;

  int unsigned burst_left = 0;
  int unsigned period_now = 10000;
  int unsigned numerator_set = NUMERATOR_RST;
  int unsigned max_rpm_set = MAX_RPM_RST;
  int unsigned timeout_set = TIMEOUT_RST;
  int          overflows_sent = 0;
  int          captures_sent = 0;
  int          settings_used = 1;
  bit          hold_req = 1'b0;

  rpm_meter_period_filter_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .capture_value_i (capture_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .rpm_o           (rpm),
    .seg_thousands_o (seg_thousands),
    .seg_hundreds_o  (seg_hundreds),
    .seg_tens_o      (seg_tens),
    .seg_ones_o      (seg_ones),
    .stopped_o       (stopped)
  );

  rpm_meter_period_filter_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .cmd_i           (cmd),
    .capture_value_i (capture_value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .rpm_i           (rpm),
    .seg_thousands_i (seg_thousands),
    .seg_hundreds_i  (seg_hundreds),
    .seg_tens_i      (seg_tens),
    .seg_ones_i      (seg_ones),
    .stopped_i       (stopped),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .stop_seen_o     (stop_seen)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  // Receiver: stretches of no stall, light stall and heavy stall, plus one long hold-off.
  initial begin : receiver
    int unsigned mode;
    int unsigned left;
    int unsigned hold_left;
    int unsigned roll;
    bit          held;
    mode = 0;
    left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        hold_left = HOLD_CYC;
        held = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(10, 150);
        end
        left--;
        roll = $urandom_range(0, 3);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= (roll == 0);
          default: out_stall <= (roll != 0);
        endcase
      end
    end
  end

  // Offers one item and returns at the edge that accepts it. Items go out in bursts.
  task automatic send_event(input logic kind, input logic [CAP_W-1:0] cap);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid      <= 1'b1;
    cmd           <= kind;
    capture_value <= cap;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == CMD_CAPTURE) captures_sent++;
    else overflows_sent++;
  endtask

  task automatic send_overflows(input int unsigned count);
    repeat (count) send_event(CMD_OVERFLOW, CAP_W'($urandom_range(0, TIMER_MAX)));
  endtask

  // Lets every outstanding result drain before registers are touched.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic apply_settings(input int unsigned num, input int unsigned max_rpm,
                                input int unsigned min_chg, input int unsigned band,
                                input int unsigned jump, input int unsigned tmo);
    write_reg(CFG_NUMERATOR, num);
    write_reg(CFG_MAX_RPM, max_rpm);
    write_reg(CFG_MIN_CHG, min_chg);
    write_reg(CFG_HIGH_BAND, band);
    write_reg(CFG_MAX_JUMP, jump);
    write_reg(CFG_TIMEOUT, tmo);
    cfg_we <= 1'b0;
    numerator_set = num & ((1 << NUM_W) - 1);
    max_rpm_set   = max_rpm & ((1 << RPM_W) - 1);
    timeout_set   = tmo & ((1 << OVF_W) - 1);
    settings_used++;
  endtask

  // Mostly whole revolutions: the overflows of a period followed by its capture. The period
  // drifts, jumps to a chosen speed, or is drawn at random; the rest is stops and noise.
  task automatic run_traffic(input int n_items);
    int          sent;
    int unsigned kind;
    int unsigned step;
    int unsigned target;
    int unsigned laps;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        step = $urandom_range(0, period_now / 16 + 2);
        if ($urandom_range(0, 1) == 1) period_now = period_now + step;
        else period_now = (period_now > step) ? period_now - step : 0;
        if (period_now > 2_000_000) period_now = 2_000_000;
      end else if (kind < 75) begin
        target = $urandom_range(1, max_rpm_set + max_rpm_set / 8 + 1);
        period_now = numerator_set / target;
      end else if (kind < 85) begin
        period_now = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1048575);
      end
      if (kind < 85) begin
        laps = period_now / TIMER_MAX;
        if (laps > timeout_set) laps = timeout_set;
        send_overflows(laps);
        pick = period_now % TIMER_MAX;
        send_event(CMD_CAPTURE, pick[CAP_W-1:0]);
        sent += laps + 1;
      end else if (kind < 93) begin
        laps = timeout_set + $urandom_range(1, 4);
        send_overflows(laps);
        send_event(CMD_CAPTURE, CAP_W'($urandom_range(0, TIMER_MAX)));
        sent += laps + 1;
      end else begin
        pick = $urandom_range(0, 1);
        send_event(pick[0], CAP_W'($urandom_range(0, TIMER_MAX)));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset settings: zero period, full-count capture, the
    // high band with a rejected and an accepted jump, too small a change, above the
    // maximum, a stop after the timeout and the capture that follows it.
    send_event(CMD_CAPTURE, 16'd0);
    send_event(CMD_CAPTURE, 16'hFFFF);
    send_event(CMD_CAPTURE, 16'd10000);
    send_event(CMD_CAPTURE, 16'd20000);
    send_event(CMD_CAPTURE, 16'd11000);
    send_event(CMD_CAPTURE, 16'd10600);
    send_event(CMD_CAPTURE, 16'd10450);
    send_event(CMD_CAPTURE, 16'd10449);
    send_event(CMD_CAPTURE, 16'd8500);
    send_event(CMD_CAPTURE, 16'd1);
    send_event(CMD_OVERFLOW, 16'hFFFF);
    send_event(CMD_CAPTURE, 16'd0);
    send_overflows(9);
    send_event(CMD_CAPTURE, 16'd0);
    send_overflows(2);
    send_event(CMD_CAPTURE, 16'hFFFF);

    // The receiver holds off for a long stretch at the start of this phase.
    hold_req = 1'b1;
    run_traffic(300);

    wait_idle();
    apply_settings((1 << NUM_W) - 1, 9999, 255, 9999, 9999, 15);
    write_reg(CFG_MIN_CHG, 0);
    cfg_we <= 1'b0;
    run_traffic(250);

    wait_idle();
    apply_settings(1, 1, 255, 0, 1, 1);
    run_traffic(80);

    repeat (3) begin
      wait_idle();
      apply_settings($urandom_range(1_000_000, (1 << NUM_W) - 1), $urandom_range(1, 9999),
                     $urandom_range(0, 255), $urandom_range(0, 9999),
                     $urandom_range(1, 9999), $urandom_range(1, 15));
      run_traffic(200);
    end

    // Upper register bits set, so masking gives the widest band, a zero timeout and
    // readings past 9999 with a blank thousands digit; spare indexes get junk.
    wait_idle();
    write_reg(CFG_SPARE_LO, 32'h3FFFFFF);
    write_reg(CFG_SPARE_HI, 32'h1555555);
    apply_settings(32'h3FFFFFF, 32'h3FFFFFF, 32'h2AAAA02, 32'h3FFFFFF, 32'h0FFFFFF,
                   32'h3FFFFF0);
    run_traffic(150);

    wait_idle();
    apply_settings(NUMERATOR_RST, MAX_RPM_RST, MIN_CHG_RST, HIGH_BAND_RST, MAX_JUMP_RST,
                   TIMEOUT_RST);
    run_traffic(200);

    wait_idle();
    repeat (TAIL_CYC) @(posedge clk);

    $display("Sent %0d overflow and %0d capture items under %0d register settings.",
             overflows_sent, captures_sent, settings_used);
    $display("Checked %0d results, %0d of them with the stop flag set, %0d mismatches.",
             checked, stop_seen, error_count);
    if (error_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/rpmf_pkg.sv
src/rpmf_ctrl.sv
src/rpmf_datapath.sv
src/rpm_meter_period_filter_top.sv
tb/rpm_meter_period_filter_checker.sv
tb/rpm_meter_period_filter_top_test.sv
